@@ hw/rtl/sbtp_pkg.sv @@
// Shared types and constants for the seven-bit text packer.
// Used by the group stage, the result drain buffer and the top level.
`default_nettype none

package sbtp_pkg;

  // Number of text bytes in one packed group.
  localparam int unsigned GROUP_SIZE = 8;

  // Result kind codes.
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_TRAILER = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // A burst of results caused by one input word. Byte 0 goes out first;
  // the last result of the burst carries final_kind, the others are data.
  typedef struct packed {
    logic [GROUP_SIZE-1:0][7:0] bytes;
    logic [3:0]                 len;
    logic [1:0]                 final_kind;
  } burst_t;

endpackage

`default_nettype wire

@@ hw/rtl/sbtp_group.sv @@
// Group stage of the seven-bit text packer: holds the unfilled group and the
// halt flag, and turns an accepted word that ends a group, ends the stream or
// is in error into a burst of results unless halted. Depends on sbtp_pkg.
`default_nettype none

module sbtp_group import sbtp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic       kind,
  input  wire logic [7:0] data_byte,
  input  wire logic       load_ok,
  output logic            burst_load,
  output burst_t          burst
);

  logic [6:0] store [GROUP_SIZE-1];
  logic [2:0] group_count;
  logic       halted;

  logic       makes_burst;
  logic       accept;
  logic       is_error;
  logic       is_full;
  logic       do_store;

  // Classify the word at the input.
  assign is_error = !kind && data_byte[7];
  assign is_full  = !kind && !data_byte[7] && (group_count == 3'(GROUP_SIZE - 1));
  assign makes_burst = !halted && (kind || data_byte[7] || is_full);

  // Only a word that yields results has to wait for the drain buffer.
  assign item_stall = makes_burst && !load_ok;
  assign accept     = item_valid && !item_stall;
  assign burst_load = accept && makes_burst;
  assign do_store   = accept && !halted && !kind && !data_byte[7] && !is_full;

  // Build the burst: packed group, raw tail with trailer, or error.
  always_comb begin
    burst = '0;
    if (kind) begin
      for (int j = 0; j < GROUP_SIZE; j++) begin
        burst.bytes[j] = {5'd0, group_count};
      end
      for (int j = 0; j < GROUP_SIZE - 1; j++) begin
        if (3'(j) < group_count) begin
          burst.bytes[j] = {1'b0, store[j]};
        end
      end
      burst.len        = {1'b0, group_count} + 4'd1;
      burst.final_kind = KIND_TRAILER;
    end else if (data_byte[7]) begin
      burst.bytes[0]   = data_byte;
      burst.len        = 4'd1;
      burst.final_kind = KIND_ERROR;
    end else begin
      // The first byte's bits spread over the top bits of the other seven.
      for (int j = 0; j < GROUP_SIZE - 2; j++) begin
        burst.bytes[j] = {store[0][j], store[j+1]};
      end
      burst.bytes[GROUP_SIZE-2] = {store[0][GROUP_SIZE-2], data_byte[6:0]};
      burst.len        = 4'(GROUP_SIZE - 1);
      burst.final_kind = KIND_DATA;
    end
  end

  // Group bytes are written at the current fill position.
  always_ff @(posedge clk) begin
    for (int i = 0; i < GROUP_SIZE - 1; i++) begin
      if (do_store && group_count == 3'(i)) begin
        store[i] <= data_byte[6:0];
      end
    end
  end

  // Fill count and halt flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_count <= '0;
      halted      <= 1'b0;
    end else if (accept) begin
      if (kind) begin
        group_count <= '0;
        halted      <= 1'b0;
      end else if (!halted) begin
        if (is_error) begin
          group_count <= '0;
          halted      <= 1'b1;
        end else if (is_full) begin
          group_count <= '0;
        end else begin
          group_count <= group_count + 3'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sbtp_drain.sv @@
// Result buffer of the seven-bit text packer: holds one burst and sends it
// out one word per cycle while result_stall is low. Depends on sbtp_pkg.
`default_nettype none

module sbtp_drain import sbtp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       burst_load,
  input  wire burst_t     burst,
  output logic            load_ok,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_byte,
  output logic            last
);

  logic [GROUP_SIZE-1:0][7:0] shift_bytes;
  logic [3:0]                 remaining;
  logic [1:0]                 final_kind;
  logic                       pop;

  assign result_valid = (remaining != 4'd0);
  assign pop          = result_valid && !result_stall;
  assign load_ok      = (remaining == 4'd0) || (remaining == 4'd1 && !result_stall);

  // The head of the buffer is the current result word.
  assign out_byte = shift_bytes[0];
  assign last     = (remaining == 4'd1);
  assign out_kind = last ? final_kind : KIND_DATA;

  // Payload: load a new burst or shift toward the head.
  always_ff @(posedge clk) begin
    if (burst_load) begin
      shift_bytes <= burst.bytes;
      final_kind  <= burst.final_kind;
    end else if (pop) begin
      shift_bytes <= shift_bytes >> 8;
    end
  end

  // Count of results still to send.
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (burst_load) begin
      remaining <= burst.len;
    end else if (pop) begin
      remaining <= remaining - 4'd1;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/seven_bit_text_packer_top.sv @@
// Seven-bit text packer, top level. A data word that only fills the group is
// taken in every cycle; a word that ends a group, ends the stream or is in error
// waits only while more than one result of the prior burst is left, or a stalled
// last one. Its first result shows in the cycle after acceptance, then one per
// cycle unless stalled; eight inputs give seven results, so one byte per cycle
// holds. Synchronous reset empties the group, clears the halt flag and buffer.
`default_nettype none

module seven_bit_text_packer_top import sbtp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic       kind,
  input  wire logic [7:0] data_byte,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_byte,
  output logic            last
);

  burst_t burst;
  logic   burst_load;
  logic   load_ok;

  // Group assembly and burst building.
  sbtp_group u_group (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .kind       (kind),
    .data_byte  (data_byte),
    .load_ok    (load_ok),
    .burst_load (burst_load),
    .burst      (burst)
  );

  // Result buffer toward the output channel.
  sbtp_drain u_drain (
    .clk          (clk),
    .rst          (rst),
    .burst_load   (burst_load),
    .burst        (burst),
    .load_ok      (load_ok),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .last         (last)
  );

endmodule

`default_nettype wire
